@@ hw/rtl/hcal_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcal_pkg
// Shared types and constants of the two-point humidity calibration block.
// ----------------------------------------------------------------------------
package hcal_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_LOW_RH_DOUBLED  = 2'd0;
    localparam logic [1:0] REG_HIGH_RH_DOUBLED = 2'd1;
    localparam logic [1:0] REG_LOW_RAW         = 2'd2;
    localparam logic [1:0] REG_HIGH_RAW        = 2'd3;

    localparam logic [7:0]  RESET_LOW_RH_DOUBLED  = 8'd0;
    localparam logic [7:0]  RESET_HIGH_RH_DOUBLED = 8'd200;
    localparam logic [15:0] RESET_LOW_RAW         = 16'd0;
    localparam logic [15:0] RESET_HIGH_RAW        = 16'd1;

    // Numerator magnitude is at most 127 * 65535 * 256, below 2^31
    localparam int NUM_W     = 31;
    localparam int DIV_STEPS = NUM_W;
    localparam int DVS_W     = 16;

    // Full scale: 100 percent in Q8
    localparam logic [14:0] RH_FULL_Q8 = 15'd25600;

    // Item traveling through the divider cells. nq starts as the numerator
    // magnitude; each cell shifts one numerator bit out of the top and one
    // quotient bit in at the bottom.
    typedef struct packed {
        logic              neg;
        logic              fault;
        logic [6:0]        rh0;
        logic [DVS_W-1:0]  dvs;
        logic [DVS_W-1:0]  rem;
        logic [NUM_W-1:0]  nq;
    } hcal_div_t;

endpackage : hcal_pkg
`default_nettype wire

@@ hw/rtl/hcal_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcal_front
// Differences, magnitudes and the numerator product, in two registered stages.
// ----------------------------------------------------------------------------
module hcal_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [15:0]       raw,
    input  wire logic [6:0]        rh0,
    input  wire logic [6:0]        rh1,
    input  wire logic [15:0]       raw0,
    input  wire logic [15:0]       raw1,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output hcal_pkg::hcal_div_t    m_data
);
    import hcal_pkg::*;

    logic               a_valid_reg;
    logic [6:0]         a_d_abs_reg;
    logic [15:0]        a_x_abs_reg;
    logic [DVS_W-1:0]   a_dvs_reg;
    logic               a_neg_reg;
    logic               a_fault_reg;
    logic [6:0]         a_rh0_reg;
    logic               a_ready;

    logic               b_valid_reg;
    hcal_div_t          b_data_reg;
    hcal_div_t          b_data_next;
    logic               b_ready;

    logic signed [7:0]  d_diff;
    logic signed [16:0] x_diff;
    logic signed [16:0] den_diff;
    logic [7:0]         d_neg;
    logic [16:0]        x_neg;
    logic [16:0]        den_neg;
    logic [6:0]         d_abs_next;
    logic [15:0]        x_abs_next;
    logic [DVS_W-1:0]   dvs_next;
    logic [22:0]        prod;

    always_comb begin
        d_diff     = $signed({1'b0, rh1}) - $signed({1'b0, rh0});
        x_diff     = $signed({raw[15], raw}) - $signed({raw0[15], raw0});
        den_diff   = $signed({raw1[15], raw1}) - $signed({raw0[15], raw0});
        d_neg      = -d_diff;
        x_neg      = -x_diff;
        den_neg    = -den_diff;
        d_abs_next = d_diff[7] ? d_neg[6:0] : d_diff[6:0];
        x_abs_next = x_diff[16] ? x_neg[15:0] : x_diff[15:0];
        dvs_next   = den_diff[16] ? den_neg[15:0] : den_diff[15:0];
    end

    assign b_ready = !b_valid_reg || m_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && a_ready) begin
            a_d_abs_reg <= d_abs_next;
            a_x_abs_reg <= x_abs_next;
            a_dvs_reg   <= dvs_next;
            a_neg_reg   <= d_diff[7] ^ x_diff[16] ^ den_diff[16];
            a_fault_reg <= (den_diff == 17'sd0);
            a_rh0_reg   <= rh0;
        end
    end

    always_comb begin
        prod              = 23'(a_d_abs_reg) * 23'(a_x_abs_reg);
        b_data_next.neg   = a_neg_reg;
        b_data_next.fault = a_fault_reg;
        b_data_next.rh0   = a_rh0_reg;
        b_data_next.dvs   = a_dvs_reg;
        b_data_next.rem   = '0;
        b_data_next.nq    = {prod, 8'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg && b_ready) begin
            b_data_reg <= b_data_next;
        end
    end

    assign m_valid = b_valid_reg;
    assign m_data  = b_data_reg;

endmodule : hcal_front
`default_nettype wire

@@ hw/rtl/hcal_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcal_div_cell
// One restoring-division step: brings in a numerator bit, trial-subtracts the
// divisor and passes the item to the next cell.
// ----------------------------------------------------------------------------
module hcal_div_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire hcal_pkg::hcal_div_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output hcal_pkg::hcal_div_t    m_data
);
    import hcal_pkg::*;

    logic              valid_reg;
    hcal_div_t         data_reg;
    hcal_div_t         data_next;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              ge;

    always_comb begin
        trial     = {s_data.rem, s_data.nq[NUM_W-1]};
        diff      = trial - {1'b0, s_data.dvs};
        ge        = (trial >= {1'b0, s_data.dvs});
        data_next = s_data;
        data_next.rem = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        data_next.nq  = {s_data.nq[NUM_W-2:0], ge};
    end

    assign s_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule : hcal_div_cell
`default_nettype wire

@@ hw/rtl/hcal_out.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcal_out
// Applies the quotient sign, adds the low-point offset, clamps to 0..100
// percent and holds the result item in the output register.
// ----------------------------------------------------------------------------
module hcal_out (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire hcal_pkg::hcal_div_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [14:0]            humidity_q8,
    output logic                   calib_fault
);
    import hcal_pkg::*;

    logic                valid_reg;
    logic [14:0]         hum_reg;
    logic [14:0]         hum_next;
    logic                fault_reg;
    logic signed [32:0]  q_mag;
    logic signed [32:0]  q_signed;
    logic signed [32:0]  sum;

    always_comb begin
        q_mag    = $signed({2'b0, s_data.nq});
        q_signed = s_data.neg ? -q_mag : q_mag;
        sum      = q_signed + $signed({18'b0, s_data.rh0, 8'b0});
        if (s_data.fault || sum[32]) begin
            hum_next = '0;
        end else if (sum > $signed({18'b0, RH_FULL_Q8})) begin
            hum_next = RH_FULL_Q8;
        end else begin
            hum_next = sum[14:0];
        end
    end

    assign s_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            hum_reg   <= hum_next;
            fault_reg <= s_data.fault;
        end
    end

    assign m_valid     = valid_reg;
    assign humidity_q8 = hum_reg;
    assign calib_fault = fault_reg;

endmodule : hcal_out
`default_nettype wire

@@ hw/rtl/humidity_two_point_calibration.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 2 front stages, 31 divider cells and 1 output register lie between
// the input accept and the result.
// Throughput: one item per cycle without output stalls; every stage holds its
// own item; the per-stage ready chain lets bubbles close up under backpressure.
// Reset: synchronous, active low; clears all valid flags and loads the
// calibration registers with their defaults.
// ----------------------------------------------------------------------------
// humidity_two_point_calibration
// Raw humidity to Q8 percent by two-point linear interpolation, with the
// division done in a chain of one-bit restoring cells.
// ----------------------------------------------------------------------------
module humidity_two_point_calibration (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wr_data,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] raw_humidity
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [14:0] humidity_q8, [15] zero
    output logic             m_tuser    // [0] calib_fault
);
    import hcal_pkg::*;

    logic [7:0]  low_rh_reg;
    logic [7:0]  high_rh_reg;
    logic [15:0] low_raw_reg;
    logic [15:0] high_raw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_rh_reg   <= RESET_LOW_RH_DOUBLED;
            high_rh_reg  <= RESET_HIGH_RH_DOUBLED;
            low_raw_reg  <= RESET_LOW_RAW;
            high_raw_reg <= RESET_HIGH_RAW;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LOW_RH_DOUBLED:  low_rh_reg   <= cfg_wr_data[7:0];
                REG_HIGH_RH_DOUBLED: high_rh_reg  <= cfg_wr_data[7:0];
                REG_LOW_RAW:         low_raw_reg  <= cfg_wr_data;
                REG_HIGH_RAW:        high_raw_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic       chain_valid [0:DIV_STEPS];
    logic       chain_ready [0:DIV_STEPS];
    hcal_div_t  chain_data  [0:DIV_STEPS];
    logic [14:0] hum_q8;

    hcal_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .raw     (s_tdata),
        .rh0     (low_rh_reg[7:1]),
        .rh1     (high_rh_reg[7:1]),
        .raw0    (low_raw_reg),
        .raw1    (high_raw_reg),
        .m_valid (chain_valid[0]),
        .m_ready (chain_ready[0]),
        .m_data  (chain_data[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
        hcal_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .s_valid (chain_valid[i]),
            .s_ready (chain_ready[i]),
            .s_data  (chain_data[i]),
            .m_valid (chain_valid[i+1]),
            .m_ready (chain_ready[i+1]),
            .m_data  (chain_data[i+1])
        );
    end

    hcal_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (chain_valid[DIV_STEPS]),
        .s_ready     (chain_ready[DIV_STEPS]),
        .s_data      (chain_data[DIV_STEPS]),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .humidity_q8 (hum_q8),
        .calib_fault (m_tuser)
    );

    assign m_tdata = {1'b0, hum_q8};

endmodule : humidity_two_point_calibration
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-point humidity calibration block: directed
// rows from a stimulus table, then random calibrations and samples, mostly
// under random backpressure; scored against row or in-bench predictor values.
// ----------------------------------------------------------------------------
module tb;
    import hcal_pkg::*;

    localparam int PHASES          = 13;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int IDLE_LIGHT_PCT  = 28;
    localparam int IDLE_HEAVY_PCT  = 73;
    localparam int DRAIN_CYCLES    = 40;

    typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

    typedef struct packed {
        logic [14:0] q8;
        logic        fault;
    } humidity_result_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  addr;
        logic [15:0] value;   // register data, or the raw sample
        logic        typed;   // expectation given in the row
        logic [14:0] q8;
        logic        fault;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;

    // predictor copy of the calibration registers
    logic [7:0]         cal_low_rh2;
    logic [7:0]         cal_high_rh2;
    logic signed [15:0] cal_low_raw;
    logic signed [15:0] cal_high_raw;

    humidity_result_t humidity_pending [$];
    humidity_result_t want_head;
    stim_row_t        stim_rows [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;
    int samples_sent;
    int results_checked;
    int faults_seen;

    humidity_two_point_calibration dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic humidity_result_t interpolate_humidity(logic signed [15:0] raw);
        longint den;
        longint rh0;
        longint rh1;
        longint num;
        longint q8;
        humidity_result_t r;
        den = longint'(cal_high_raw) - longint'(cal_low_raw);
        rh0 = longint'(cal_low_rh2 >> 1);
        rh1 = longint'(cal_high_rh2 >> 1);
        if (den == 0) begin
            r.q8    = '0;
            r.fault = 1'b1;
            return r;
        end
        num = (rh1 - rh0) * (longint'(raw) - longint'(cal_low_raw)) * 256;
        // signed division truncates toward zero
        q8 = rh0 * 256 + num / den;
        if (q8 < 0)
            q8 = 0;
        if (q8 > longint'(RH_FULL_Q8))
            q8 = longint'(RH_FULL_Q8);
        r.q8    = q8[14:0];
        r.fault = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t wr_row(logic [1:0] addr, logic [15:0] value);
        stim_row_t row;
        row = '0;
        row.kind  = ROW_WRITE;
        row.addr  = addr;
        row.value = value;
        return row;
    endfunction

    function automatic stim_row_t chk_row(logic [15:0] raw, logic [14:0] q8, logic fault);
        stim_row_t row;
        row = '0;
        row.kind  = ROW_ITEM;
        row.value = raw;
        row.typed = 1'b1;
        row.q8    = q8;
        row.fault = fault;
        return row;
    endfunction

    function automatic stim_row_t pred_row(logic [15:0] raw);
        stim_row_t row;
        row = '0;
        row.kind  = ROW_ITEM;
        row.value = raw;
        return row;
    endfunction

    function automatic logic [15:0] pick_raw();
        int lo;
        int hi;
        int sel;
        lo = (cal_low_raw < cal_high_raw) ? int'(cal_low_raw) : int'(cal_high_raw);
        hi = (cal_low_raw < cal_high_raw) ? int'(cal_high_raw) : int'(cal_low_raw);
        sel = $urandom_range(9);
        if (sel < 6) begin
            // widen the span a little so both clamps get hit
            lo = (lo - 64 < -32768) ? -32768 : lo - 64;
            hi = (hi + 64 > 32767) ? 32767 : hi + 64;
            return 16'(lo + int'($urandom_range(hi - lo)));
        end
        if (sel < 8)
            return 16'($urandom);
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return cal_low_raw;
            4: return cal_high_raw;
            default: return cal_low_raw + 16'(int'($urandom_range(2)) - 1);
        endcase
    endfunction

    function automatic logic [15:0] pick_raw_point();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_rh_point();
        case ($urandom_range(4))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // Write one register once nothing is in flight.
    task automatic write_cfg(input logic [1:0] addr, input logic [15:0] value);
        s_tvalid <= 1'b0;
        while (humidity_pending.size() != 0)
            @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= value;
        @(posedge aclk);
        case (addr)
            REG_LOW_RH_DOUBLED:  cal_low_rh2  = value[7:0];
            REG_HIGH_RH_DOUBLED: cal_high_rh2 = value[7:0];
            REG_LOW_RAW:         cal_low_raw  = value;
            REG_HIGH_RAW:        cal_high_raw = value;
            default: ;
        endcase
    endtask

    // Offer one sample; record its expectation once it is accepted.
    task automatic send_sample(input logic [15:0] raw, input humidity_result_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        humidity_pending.push_back(want);
        samples_sent++;
    endtask

    // Score results and drive backpressure.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (humidity_pending.size() == 0) begin
                $display("%0t: unexpected result: actual q8=%0d fault=%0b",
                         $time, m_tdata[14:0], m_tuser);
                mismatch_count++;
            end else begin
                want_head = humidity_pending.pop_front();
                results_checked++;
                if (m_tuser)
                    faults_seen++;
                if (m_tdata !== {1'b0, want_head.q8}) begin
                    $display("%0t: humidity mismatch: expected tdata=%0d actual tdata=%0d",
                             $time, want_head.q8, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== want_head.fault) begin
                    $display("%0t: fault flag mismatch: expected %0b actual %0b",
                             $time, want_head.fault, m_tuser);
                    mismatch_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #2_000_000;
        $display("timeout at %0t with %0d results outstanding", $time,
                 humidity_pending.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        stim_row_t        row;
        humidity_result_t want;
        logic [15:0]      raw_a;
        logic             wrote;
        int               phase;

        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_addr        = '0;
        cfg_wr_data     = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        send_idle_pct   = IDLE_LIGHT_PCT;
        recv_idle_pct   = IDLE_HEAVY_PCT;
        mismatch_count  = 0;
        samples_sent    = 0;
        results_checked = 0;
        faults_seen     = 0;
        cal_low_rh2     = RESET_LOW_RH_DOUBLED;
        cal_high_rh2    = RESET_HIGH_RH_DOUBLED;
        cal_low_raw     = RESET_LOW_RAW;
        cal_high_raw    = RESET_HIGH_RAW;

        // reset calibration: 0 .. 100 percent over raw 0 .. 1
        stim_rows.push_back(chk_row(16'h0000, 15'd0, 1'b0));
        stim_rows.push_back(chk_row(16'h0001, 15'd25600, 1'b0));
        stim_rows.push_back(chk_row(16'hFFFF, 15'd0, 1'b0));
        stim_rows.push_back(chk_row(16'h7FFF, 15'd25600, 1'b0));
        stim_rows.push_back(chk_row(16'h8000, 15'd0, 1'b0));
        // equal raw points
        stim_rows.push_back(wr_row(REG_HIGH_RAW, 16'h0000));
        stim_rows.push_back(chk_row(16'h1234, 15'd0, 1'b1));
        stim_rows.push_back(chk_row(16'h8000, 15'd0, 1'b1));
        stim_rows.push_back(chk_row(16'h7FFF, 15'd0, 1'b1));
        // falling humidity over the full raw span, rh0 above 100 percent
        stim_rows.push_back(wr_row(REG_LOW_RH_DOUBLED, 16'd255));
        stim_rows.push_back(wr_row(REG_HIGH_RH_DOUBLED, 16'd0));
        stim_rows.push_back(wr_row(REG_LOW_RAW, 16'h8000));
        stim_rows.push_back(wr_row(REG_HIGH_RAW, 16'h7FFF));
        stim_rows.push_back(chk_row(16'h8000, 15'd25600, 1'b0));
        stim_rows.push_back(chk_row(16'h7FFF, 15'd0, 1'b0));
        stim_rows.push_back(pred_row(16'h0000));
        stim_rows.push_back(pred_row(16'h3039));
        // falling raw points, an odd doubled percentage
        stim_rows.push_back(wr_row(REG_LOW_RH_DOUBLED, 16'd40));
        stim_rows.push_back(wr_row(REG_HIGH_RH_DOUBLED, 16'd161));
        stim_rows.push_back(wr_row(REG_LOW_RAW, 16'h4E20));
        stim_rows.push_back(wr_row(REG_HIGH_RAW, 16'hD8F0));
        stim_rows.push_back(chk_row(16'h4E20, 15'd5120, 1'b0));
        stim_rows.push_back(pred_row(16'hD8F0));
        stim_rows.push_back(pred_row(16'h1388));
        stim_rows.push_back(pred_row(16'h7FFF));
        stim_rows.push_back(pred_row(16'h8000));
        // widest numerator
        stim_rows.push_back(wr_row(REG_LOW_RH_DOUBLED, 16'd0));
        stim_rows.push_back(wr_row(REG_HIGH_RH_DOUBLED, 16'd254));
        stim_rows.push_back(wr_row(REG_LOW_RAW, 16'h8000));
        stim_rows.push_back(wr_row(REG_HIGH_RAW, 16'h7FFF));
        stim_rows.push_back(chk_row(16'h8000, 15'd0, 1'b0));
        stim_rows.push_back(chk_row(16'h7FFF, 15'd25600, 1'b0));
        stim_rows.push_back(pred_row(16'h5555));
        stim_rows.push_back(pred_row(16'hAAAA));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        wrote = 1'b0;
        for (int i = 0; i < stim_rows.size(); i++) begin
            row = stim_rows[i];
            if (row.kind == ROW_WRITE) begin
                write_cfg(row.addr, row.value);
                wrote = 1'b1;
            end else begin
                if (wrote) begin
                    cfg_wr_en <= 1'b0;
                    wrote = 1'b0;
                end
                if (row.typed) begin
                    want.q8    = row.q8;
                    want.fault = row.fault;
                end else begin
                    want = interpolate_humidity(row.value);
                end
                send_sample(row.value, want);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            // sender light / receiver heavy, then swapped, then no idling
            if (phase < 4) begin
                send_idle_pct = IDLE_LIGHT_PCT;
                recv_idle_pct = IDLE_HEAVY_PCT;
            end else if (phase < 8) begin
                send_idle_pct = IDLE_HEAVY_PCT;
                recv_idle_pct = IDLE_LIGHT_PCT;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // upper data bits of the 8-bit registers are don't-care
            write_cfg(REG_LOW_RH_DOUBLED, {8'($urandom), pick_rh_point()});
            write_cfg(REG_HIGH_RH_DOUBLED, {8'($urandom), pick_rh_point()});
            raw_a = pick_raw_point();
            write_cfg(REG_LOW_RAW, raw_a);
            // now and then make the points collide
            write_cfg(REG_HIGH_RAW, ($urandom_range(7) == 0) ? raw_a : pick_raw_point());
            cfg_wr_en <= 1'b0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                raw_a = pick_raw();
                send_sample(raw_a, interpolate_humidity(raw_a));
            end
        end
        s_tvalid <= 1'b0;

        while (humidity_pending.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d samples over %0d random calibrations plus directed rows.",
                 samples_sent, PHASES);
        $display("Checked %0d results, %0d with the fault flag, %0d mismatches.",
                 results_checked, faults_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/hcal_pkg.sv
hw/rtl/hcal_front.sv
hw/rtl/hcal_div_cell.sv
hw/rtl/hcal_out.sv
hw/rtl/humidity_two_point_calibration.sv
verif/tb.sv
